>>> rtl/core/complex_sample_histogram_unit_assert.svh
// Assertion macros for the histogram unit.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef COMPLEX_SAMPLE_HISTOGRAM_UNIT_ASSERT_SVH
`define COMPLEX_SAMPLE_HISTOGRAM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram unit: next-cycle check failed");

`endif

>>> rtl/core/csh_pkg.sv
package csh_pkg;

    // Field widths of the request and response.
    localparam int SAMPLE_W   = 16;
    localparam int BIN_IDX_W  = 12;
    localparam int COUNT_W    = 32;
    localparam int OPCODE_W   = 2;

    // Binning: each part is shifted right by this many bits before the offset.
    localparam int BIN_SHIFT  = 4;
    // Signed width that holds a shifted part plus the largest offset.
    localparam int SUM_W      = 18;

    // Position counters and their limits.
    localparam int ANT_W        = 4;
    localparam int NANT_W       = 5;
    localparam int CHAN_W       = 10;
    localparam int NCHAN_W      = 11;
    localparam int MAX_ANTENNAS = 16;
    localparam int MAX_CHANNELS = 1024;

    // Default histogram depth.
    localparam int DEF_NUM_BINS = 4096;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ANTENNAS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_ANTENNA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_CHANNELS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHANNEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_CHANNEL     = 3'd5;

    // Request operations.
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]        opcode;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic [BIN_IDX_W-1:0]       bin_index;
    } req_item_t;

    typedef struct packed {
        logic               sample_counted;
        logic [COUNT_W-1:0] real_count;
        logic [COUNT_W-1:0] imag_count;
    } rsp_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;        // a request is accepted at this edge
        logic commit;      // finish the item: write back counts, form the response
        logic clear_step;  // write one zero entry of the clearing sweep
        logic load_out;    // move the pending response into the output register
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;    // output register is empty or emptied at this edge
        logic item_clear;  // the offered request is a clear operation
        logic clear_last;  // the sweep is at its last entry
    } dp_status_t;

endpackage

>>> rtl/core/csh_ram.sv
module csh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/csh_ctrl.sv
module csh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  csh_pkg::dp_status_t sts,
    output csh_pkg::ctrl_cmd_t  cmd
);

    import csh_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   can_take;

    // A request is taken when idle, or while the previous response leaves.
    assign can_take  = (state_reg == ST_IDLE) || ((state_reg == ST_EMIT) && sts.out_free);
    assign req_stall = !can_take;

    always_comb
    begin
        cmd.take       = req_valid && can_take;
        cmd.commit     = (state_reg == ST_EXEC);
        cmd.clear_step = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        cmd.load_out   = (state_reg == ST_EMIT) && sts.out_free;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.take)
                begin
                    state_next = sts.item_clear ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_EMIT;
            end
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (cmd.take)
                    begin
                        state_next = sts.item_clear ? ST_CLEAR : ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Reset starts with a sweep that zeroes both histograms.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/csh_datapath.sv
module csh_datapath #(
    parameter int NUM_BINS = csh_pkg::DEF_NUM_BINS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  csh_pkg::req_item_t             req,
    input  logic                           cfg_write,
    input  logic [csh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  csh_pkg::ctrl_cmd_t             cmd,
    output csh_pkg::dp_status_t            sts,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output csh_pkg::rsp_item_t             rsp
);

    import csh_pkg::*;

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int PART_W = SAMPLE_W - BIN_SHIFT;
    localparam int RANGE_W = BIN_IDX_W > BIN_W ? BIN_IDX_W + 1 : BIN_W + 1;
    localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(NUM_BINS / 2);
    localparam logic signed [SUM_W-1:0] MAX_S  = SUM_W'(NUM_BINS - 1);

    // Configuration registers.
    logic [NANT_W-1:0]  num_antennas_reg;
    logic [NCHAN_W-1:0] num_channels_reg;
    logic [ANT_W-1:0]   selected_antenna_reg;
    logic               all_channels_reg;
    logic [CHAN_W-1:0]  first_channel_reg;
    logic [CHAN_W-1:0]  last_channel_reg;

    // Stream position.
    logic [ANT_W-1:0]   ant_pos_reg;
    logic [ANT_W-1:0]   ant_pos_next;
    logic [CHAN_W-1:0]  chan_pos_reg;
    logic [CHAN_W-1:0]  chan_pos_next;

    // Item in flight.
    logic               counted_reg;
    logic               counted_next;
    logic               rd_ok_reg;
    logic               rd_ok_next;
    logic [BIN_W-1:0]   rb_reg;
    logic [BIN_W-1:0]   ib_reg;

    // Clearing sweep and response path.
    logic [BIN_W-1:0]   clr_cnt_reg;
    rsp_item_t          pend_reg;
    rsp_item_t          out_reg;
    logic               out_valid_reg;

    logic [NANT_W-1:0]  nant;
    logic [NCHAN_W-1:0] nchan;
    logic               chan_ok;
    logic               is_sample;
    logic               is_read;
    logic [BIN_W-1:0]   rb;
    logic [BIN_W-1:0]   ib;
    logic [BIN_W-1:0]   idx;
    logic               idx_in_range;
    logic [BIN_W-1:0]   re_raddr;
    logic [BIN_W-1:0]   im_raddr;
    logic [BIN_W-1:0]   re_waddr;
    logic [BIN_W-1:0]   im_waddr;
    logic [COUNT_W-1:0] re_wdata;
    logic [COUNT_W-1:0] im_wdata;
    logic               hist_we;
    logic [COUNT_W-1:0] re_rdata;
    logic [COUNT_W-1:0] im_rdata;

    // Shift a part right, offset it by half the bin count, saturate to the ends.
    function automatic logic [BIN_W-1:0] bin_of(input logic [SAMPLE_W-1:0] part);
        logic signed [PART_W-1:0] v;
        logic signed [SUM_W-1:0]  b;
        logic [BIN_W-1:0]         r;
        v = signed'(part[SAMPLE_W-1:BIN_SHIFT]);
        b = SUM_W'(v) + HALF_S;
        if (b < 0)
        begin
            r = '0;
        end
        else if (b > MAX_S)
        begin
            r = BIN_W'(MAX_S);
        end
        else
        begin
            r = BIN_W'(b);
        end
        return r;
    endfunction

    // Clamp the stream geometry to the supported range.
    always_comb
    begin
        if (num_antennas_reg == '0)
        begin
            nant = NANT_W'(1);
        end
        else if (num_antennas_reg > NANT_W'(MAX_ANTENNAS))
        begin
            nant = NANT_W'(MAX_ANTENNAS);
        end
        else
        begin
            nant = num_antennas_reg;
        end
        if (num_channels_reg == '0)
        begin
            nchan = NCHAN_W'(1);
        end
        else if (num_channels_reg > NCHAN_W'(MAX_CHANNELS))
        begin
            nchan = NCHAN_W'(MAX_CHANNELS);
        end
        else
        begin
            nchan = num_channels_reg;
        end
    end

    // Decode the offered request.
    assign is_sample    = (req.opcode == OP_SAMPLE);
    assign is_read      = (req.opcode == OP_READ);
    assign rb           = bin_of(req.sample_re);
    assign ib           = bin_of(req.sample_im);
    assign idx          = BIN_W'(req.bin_index);
    assign idx_in_range = RANGE_W'(req.bin_index) < RANGE_W'(NUM_BINS);

    // Selection of the current sample position.
    assign chan_ok = all_channels_reg ||
                     ((chan_pos_reg >= first_channel_reg) && (chan_pos_reg <= last_channel_reg));

    always_comb
    begin
        counted_next = is_sample && (ant_pos_reg == selected_antenna_reg) && chan_ok;
        rd_ok_next   = is_read && idx_in_range;
    end

    // Position advance: antenna fastest, then channel.
    always_comb
    begin
        ant_pos_next  = ant_pos_reg;
        chan_pos_next = chan_pos_reg;
        if (req.opcode == OP_CLEAR)
        begin
            ant_pos_next  = '0;
            chan_pos_next = '0;
        end
        else if (is_sample)
        begin
            if ((NANT_W'(ant_pos_reg) + NANT_W'(1)) >= nant)
            begin
                ant_pos_next = '0;
                if ((NCHAN_W'(chan_pos_reg) + NCHAN_W'(1)) >= nchan)
                begin
                    chan_pos_next = '0;
                end
                else
                begin
                    chan_pos_next = chan_pos_reg + CHAN_W'(1);
                end
            end
            else
            begin
                ant_pos_next = ant_pos_reg + ANT_W'(1);
            end
        end
    end

    // Memory ports: reads at acceptance, write-back or zero fill afterwards.
    assign re_raddr = is_read ? idx : rb;
    assign im_raddr = is_read ? idx : ib;
    assign hist_we  = cmd.clear_step || (cmd.commit && counted_reg);
    assign re_waddr = cmd.clear_step ? clr_cnt_reg : rb_reg;
    assign im_waddr = cmd.clear_step ? clr_cnt_reg : ib_reg;
    assign re_wdata = cmd.clear_step ? '0 : re_rdata + COUNT_W'(1);
    assign im_wdata = cmd.clear_step ? '0 : im_rdata + COUNT_W'(1);

    csh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_real_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (re_waddr),
        .wdata (re_wdata),
        .re    (cmd.take),
        .raddr (re_raddr),
        .rdata (re_rdata)
    );

    csh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_imag_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (im_waddr),
        .wdata (im_wdata),
        .re    (cmd.take),
        .raddr (im_raddr),
        .rdata (im_rdata)
    );

    // Status toward the controller.
    always_comb
    begin
        sts.out_free   = !out_valid_reg || !rsp_stall;
        sts.item_clear = (req.opcode == OP_CLEAR);
        sts.clear_last = (clr_cnt_reg == BIN_W'(NUM_BINS - 1));
    end

    // Configuration, positions and control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_antennas_reg     <= NANT_W'(2);
            num_channels_reg     <= NCHAN_W'(128);
            selected_antenna_reg <= '0;
            all_channels_reg     <= 1'b1;
            first_channel_reg    <= '0;
            last_channel_reg     <= CHAN_W'(127);
            ant_pos_reg          <= '0;
            chan_pos_reg         <= '0;
            counted_reg          <= 1'b0;
            rd_ok_reg            <= 1'b0;
            clr_cnt_reg          <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NUM_ANTENNAS:     num_antennas_reg     <= cfg_data[NANT_W-1:0];
                    CFG_NUM_CHANNELS:     num_channels_reg     <= cfg_data[NCHAN_W-1:0];
                    CFG_SELECTED_ANTENNA: selected_antenna_reg <= cfg_data[ANT_W-1:0];
                    CFG_ALL_CHANNELS:     all_channels_reg     <= cfg_data[0];
                    CFG_FIRST_CHANNEL:    first_channel_reg    <= cfg_data[CHAN_W-1:0];
                    CFG_LAST_CHANNEL:     last_channel_reg     <= cfg_data[CHAN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.take)
            begin
                ant_pos_reg  <= ant_pos_next;
                chan_pos_reg <= chan_pos_next;
                counted_reg  <= counted_next;
                rd_ok_reg    <= rd_ok_next;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= sts.clear_last ? '0 : clr_cnt_reg + BIN_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rb_reg <= rb;
            ib_reg <= ib;
        end
        if (cmd.commit)
        begin
            pend_reg.sample_counted <= counted_reg;
            pend_reg.real_count     <= rd_ok_reg ? re_rdata : '0;
            pend_reg.imag_count     <= rd_ok_reg ? im_rdata : '0;
        end
        if (cmd.load_out)
        begin
            out_reg <= pend_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

>>> rtl/core/complex_sample_histogram_unit.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  csh_pkg::req_item_t
// rsp      out        rsp_valid / rsp_stall  csh_pkg::rsp_item_t
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// For a sample or read request the histogram memories are read at acceptance and
// the incremented count is written back in the next cycle. The next request is
// read only after that write-back, so it never sees a stale count.
// A clear request runs a zero fill over every bin before its response is formed.
// After reset a clearing pass over every bin runs before the first request is taken.
// One finished response may wait in the output register while the next request
// is worked on; a further request waits until that response is taken.
module complex_sample_histogram_unit #(
    parameter int NUM_BINS = csh_pkg::DEF_NUM_BINS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  csh_pkg::req_item_t             req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output csh_pkg::rsp_item_t             rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [csh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csh_pkg::CFG_DATA_W-1:0] cfg_data
);

    import csh_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // Registers accept a write in any cycle.
    assign cfg_ready = 1'b1;

    csh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    csh_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    `include "complex_sample_histogram_unit_assert.svh"

    // No request is taken during the zero fill.
    `CSH_ASSERT_SAME(a_no_take_in_clear, cmd.clear_step, req_stall)
    // A write-back never collides with the zero fill.
    `CSH_ASSERT_SAME(a_commit_not_clear, cmd.clear_step, !cmd.commit)
    // An accepted request is always followed by a working cycle.
    `CSH_ASSERT_NEXT(a_take_then_work, cmd.take, !cmd.take)
    // A held response is never overwritten.
    `CSH_ASSERT_SAME(a_no_overwrite, cmd.load_out, !(rsp_valid && rsp_stall))

endmodule
